FILE: rtl/assert_macros.svh
// Assertion macros used by the checker of the stereo mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition and consequence in the same cycle.
`define ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/smsc_pkg.sv
// Package of the stereo mixer: widths, register codes, types and the clip table function.
`timescale 1ns / 1ps

package smsc_pkg;

    localparam int DEF_CHANNELS   = 4;
    localparam int DEF_CLIP_DEPTH = 256;

    localparam int IN_CHANNELS = 4;
    localparam int SIDES       = 2;
    localparam int LEFT        = 0;
    localparam int RIGHT       = 1;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int CNT_W       = 3;
    localparam int IN_TDATA_W  = SIDES * IN_CHANNELS * SAMPLE_W;
    localparam int OUT_TDATA_W = SIDES * SAMPLE_W;

    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_LSB     = 2;
    localparam int REG_IDX_W   = 3;

    // Register codes, one per 32-bit word
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN0  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN1  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN2  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN3  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MASTER = 3'd5;

    localparam logic [CNT_W-1:0]  RST_ACTIVE = 3'd2;
    localparam logic [GAIN_W-1:0] RST_GAIN   = 16'd16384;

    // Datapath widths: sample*gain, then *master (Q.43), then sum of four
    localparam int PROD_W   = 32;
    localparam int TERM_W   = 48;
    localparam int ACC_W    = 50;
    localparam int MAG_W    = 46;
    localparam int FRAC_LSB = 30;
    localparam int FRAC_W   = 16;
    localparam int ENTRY_W  = 15;

    localparam logic [ENTRY_W-1:0] FULL_SCALE = 15'h7fff;
    localparam logic [FRAC_W:0]    HALF_LSB   = 17'h08000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [TERM_W-1:0]   term_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
    localparam int          TAYLOR_TERMS = 12;
    localparam int          SQUARINGS    = 5;

    // Shift-and-subtract quotient, evaluated at elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry j of the tanh table: round(32768 * tanh(8*j/depth)), limited to full scale
    function automatic logic [ENTRY_W-1:0] clip_entry(input int unsigned j,
                                                      input int unsigned depth);
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] v;
        u    = udiv64(64'(j) << 30, 64'(depth) << 1);
        term = ONE_Q30;
        e    = ONE_Q30;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = udiv64((term * u) >> 30, 64'(k));
            if ((k & 1) != 0) begin
                e = e - term;
            end
            else begin
                e = e + term;
            end
        end
        for (int s = 0; s < SQUARINGS; s++) begin
            e = (e * e + (ONE_Q30 >> 1)) >> 30;
        end
        if (e > ONE_Q30) begin
            e = ONE_Q30;
        end
        den = ONE_Q30 + e;
        v   = udiv64((ONE_Q30 - e) * 64'd32768 + (den >> 1), den);
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[ENTRY_W-1:0];
    endfunction

endpackage

FILE: rtl/stereo_mixer_soft_clip_core.sv
// Top level of the stereo mixer: gain scaling, summing and tanh soft clip.
`timescale 1ns / 1ps

// Stereo mixer with soft clip.
// Input stream (s_tvalid/s_tready/s_tdata): one frame per item, left and right
// samples of four channels, signed Q1.15. Only the first active_channels lanes
// (at most CHANNELS) count; the rest are ignored.
// Output stream (m_tvalid/m_tready/m_tdata): the soft-clipped left and right mix.
// APB port: active_channels, four channel gains and a master level, at 4*index.
// A count write of zero or above CHANNELS is dropped. Write only while idle.
// Throughput: one item per cycle while the output is not stalled. Items pass
// through eight register stages (two multiplier stages, sum, magnitude, table
// index, table read, interpolation, sign) before m_tvalid. The table read and
// the interpolation multiply set the stage depth.
// Stalls: each stage holds its item while the next is full, and bubbles close
// up, so input is taken while a finished result waits as long as any stage is
// empty. Nothing is lost or repeated.
// Reset: valid bits clear at once; registers return to two channels at unity
// gain. The tanh table is a constant built at elaboration, so no fill pass.
module stereo_mixer_soft_clip_core #(
    parameter int CHANNELS         = smsc_pkg::DEF_CHANNELS,
    parameter int CLIP_TABLE_DEPTH = smsc_pkg::DEF_CLIP_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata, from bit 0: ch0_left, ch0_right, ch1_left, ch1_right,
    // ch2_left, ch2_right, ch3_left, ch3_right
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [smsc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // m_tdata, from bit 0: mix_left, mix_right
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [smsc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smsc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [smsc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [smsc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    import smsc_pkg::*;

    localparam int STAGES      = 8;
    localparam int STG_SCALE   = 0;
    localparam int STG_MASTER  = 1;
    localparam int STG_SUM     = 2;
    localparam int STG_MAG     = 3;
    localparam int STG_INDEX   = 4;
    localparam int STG_READ    = 5;
    localparam int STG_INTERP  = 6;
    localparam int STG_OUT     = 7;

    localparam int DEPTH_W = $clog2(CLIP_TABLE_DEPTH + 1);
    localparam int IDX_W   = $clog2(CLIP_TABLE_DEPTH);
    localparam int ROM_AW  = DEPTH_W;
    localparam int SCALE_W = MAG_W + DEPTH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]     active_channels_reg, active_channels_next;
    logic [GAIN_W-1:0]    gain_reg [IN_CHANNELS];
    logic [GAIN_W-1:0]    gain_next [IN_CHANNELS];
    logic [GAIN_W-1:0]    master_level_reg, master_level_next;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[REG_LSB +: REG_IDX_W];

    always_comb
    begin
        active_channels_next = active_channels_reg;
        gain_next            = gain_reg;
        master_level_next    = master_level_reg;
        if (cfg_write) begin
            unique case (reg_idx)
                REG_ACTIVE:
                begin
                    // Drop a count of zero or above the lanes built
                    if ((pwdata[CNT_W-1:0] != '0) &&
                        (pwdata[CNT_W-1:0] <= CNT_W'(CHANNELS))) begin
                        active_channels_next = pwdata[CNT_W-1:0];
                    end
                end
                REG_GAIN0:  gain_next[0]      = pwdata[GAIN_W-1:0];
                REG_GAIN1:  gain_next[1]      = pwdata[GAIN_W-1:0];
                REG_GAIN2:  gain_next[2]      = pwdata[GAIN_W-1:0];
                REG_GAIN3:  gain_next[3]      = pwdata[GAIN_W-1:0];
                REG_MASTER: master_level_next = pwdata[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_channels_reg <= RST_ACTIVE;
            master_level_reg    <= RST_GAIN;
            for (int c = 0; c < IN_CHANNELS; c++) begin
                gain_reg[c] <= RST_GAIN;
            end
        end
        else begin
            active_channels_reg <= active_channels_next;
            master_level_reg    <= master_level_next;
            gain_reg            <= gain_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ACTIVE: prdata = APB_DATA_W'(active_channels_reg);
            REG_GAIN0:  prdata = APB_DATA_W'(gain_reg[0]);
            REG_GAIN1:  prdata = APB_DATA_W'(gain_reg[1]);
            REG_GAIN2:  prdata = APB_DATA_W'(gain_reg[2]);
            REG_GAIN3:  prdata = APB_DATA_W'(gain_reg[3]);
            REG_MASTER: prdata = APB_DATA_W'(master_level_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Tanh table, built at elaboration; entry depth is full scale saturation
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] clip_rom [CLIP_TABLE_DEPTH + 1];

    for (genvar j = 0; j <= CLIP_TABLE_DEPTH; j++) begin : g_rom
        localparam logic [ENTRY_W-1:0] ENTRY = clip_entry(j, CLIP_TABLE_DEPTH);
        assign clip_rom[j] = ENTRY;
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage takes a new item when it is empty or its
    // own item moves on in the same cycle
    // ------------------------------------------------------------------
    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] up_valid;
    logic [STAGES-1:0] stage_ready;
    logic [STAGES-1:0] load;

    assign up_valid = {valid_reg[STAGES-2:0], s_tvalid};

    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        for (int k = 0; k < STAGES; k++) begin
            valid_next[k] = stage_ready[k] ? up_valid[k] : valid_reg[k];
            load[k]       = stage_ready[k] && up_valid[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_ready[STG_SCALE];
    assign m_tvalid = valid_reg[STG_OUT];

    // ------------------------------------------------------------------
    // Stage 0: sample times channel gain; unused lanes forced to zero
    // ------------------------------------------------------------------
    prod_t prod_reg  [CHANNELS][SIDES];
    prod_t prod_next [CHANNELS][SIDES];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        for (genvar sd = 0; sd < SIDES; sd++) begin : g_side
            sample_t                 smp;
            logic signed [PROD_W:0]  wide;
            assign smp  = (CNT_W'(c) < active_channels_reg) ?
                          sample_t'(s_tdata[(SIDES*c+sd)*SAMPLE_W +: SAMPLE_W]) : '0;
            assign wide = smp * $signed({1'b0, gain_reg[c]});
            assign prod_next[c][sd] = wide[PROD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_SCALE]) begin
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: times master level, exact Q.43 term
    // ------------------------------------------------------------------
    term_t term_reg  [CHANNELS][SIDES];
    term_t term_next [CHANNELS][SIDES];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_master
        for (genvar sd = 0; sd < SIDES; sd++) begin : g_side
            logic signed [TERM_W:0] wide;
            assign wide = prod_reg[c][sd] * $signed({1'b0, master_level_reg});
            assign term_next[c][sd] = wide[TERM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_MASTER]) begin
            term_reg <= term_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum the lanes per side
    // ------------------------------------------------------------------
    acc_t sum_reg  [SIDES];
    acc_t sum_next [SIDES];

    always_comb
    begin
        for (int sd = 0; sd < SIDES; sd++) begin
            sum_next[sd] = '0;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_next[sd] = sum_next[sd] + ACC_W'(term_reg[c][sd]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_SUM]) begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sign and magnitude; 8.0 or more saturates
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mag_reg  [SIDES];
    logic [MAG_W-1:0] mag_next [SIDES];
    logic [SIDES-1:0] neg3_reg, neg3_next;
    logic [SIDES-1:0] sat3_reg, sat3_next;

    always_comb
    begin
        logic [ACC_W-1:0] full;
        full = '0;
        for (int sd = 0; sd < SIDES; sd++) begin
            neg3_next[sd] = sum_reg[sd][ACC_W-1];
            full          = neg3_next[sd] ? (~sum_reg[sd] + 1'b1) : sum_reg[sd];
            sat3_next[sd] = |full[ACC_W-1:MAG_W];
            mag_next[sd]  = full[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_MAG]) begin
            mag_reg  <= mag_next;
            neg3_reg <= neg3_next;
            sat3_reg <= sat3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale by table depth, split into index and fraction
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  idx_reg   [SIDES];
    logic [IDX_W-1:0]  idx_next  [SIDES];
    logic [FRAC_W-1:0] frac4_reg  [SIDES];
    logic [FRAC_W-1:0] frac4_next [SIDES];
    logic [SIDES-1:0]  neg4_reg, sat4_reg;

    always_comb
    begin
        logic [SCALE_W-1:0] scaled;
        scaled = '0;
        for (int sd = 0; sd < SIDES; sd++) begin
            scaled = {{DEPTH_W{1'b0}}, mag_reg[sd]} * SCALE_W'(CLIP_TABLE_DEPTH);
            idx_next[sd]   = scaled[MAG_W +: IDX_W];
            frac4_next[sd] = scaled[FRAC_LSB +: FRAC_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_INDEX]) begin
            idx_reg   <= idx_next;
            frac4_reg <= frac4_next;
            neg4_reg  <= neg3_reg;
            sat4_reg  <= sat3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: read the two neighbouring table entries
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] lo_reg  [SIDES];
    logic [ENTRY_W-1:0] lo_next [SIDES];
    logic [ENTRY_W-1:0] hi_reg  [SIDES];
    logic [ENTRY_W-1:0] hi_next [SIDES];
    logic [FRAC_W-1:0]  frac5_reg [SIDES];
    logic [SIDES-1:0]   neg5_reg, sat5_reg;

    always_comb
    begin
        logic [ROM_AW-1:0] addr_lo;
        logic [ROM_AW-1:0] addr_hi;
        addr_lo = '0;
        addr_hi = '0;
        for (int sd = 0; sd < SIDES; sd++) begin
            addr_lo     = ROM_AW'(idx_reg[sd]);
            addr_hi     = addr_lo + ROM_AW'(1);
            lo_next[sd] = clip_rom[addr_lo];
            hi_next[sd] = clip_rom[addr_hi];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_READ]) begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            frac5_reg <= frac4_reg;
            neg5_reg  <= neg4_reg;
            sat5_reg  <= sat4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: interpolate with rounding, toward the higher neighbour
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] clip_reg  [SIDES];
    logic [ENTRY_W-1:0] clip_next [SIDES];
    logic [SIDES-1:0]   neg6_reg;

    always_comb
    begin
        logic                        rising;
        logic [ENTRY_W-1:0]          delta;
        logic [ENTRY_W+FRAC_W-1:0]   step_prod;
        logic [ENTRY_W+FRAC_W:0]     step_rnd;
        logic [FRAC_W-1:0]           step;
        logic [ENTRY_W:0]            level;
        rising    = 1'b0;
        delta     = '0;
        step_prod = '0;
        step_rnd  = '0;
        step      = '0;
        level     = '0;
        for (int sd = 0; sd < SIDES; sd++) begin
            rising    = hi_reg[sd] >= lo_reg[sd];
            delta     = rising ? (hi_reg[sd] - lo_reg[sd]) : (lo_reg[sd] - hi_reg[sd]);
            step_prod = delta * frac5_reg[sd];
            step_rnd  = {1'b0, step_prod} + (ENTRY_W+FRAC_W+1)'(HALF_LSB);
            step      = step_rnd[FRAC_W +: FRAC_W];
            level     = rising ? ({1'b0, lo_reg[sd]} + step) : ({1'b0, lo_reg[sd]} - step);
            if (sat5_reg[sd] || (level > {1'b0, FULL_SCALE})) begin
                clip_next[sd] = FULL_SCALE;
            end
            else begin
                clip_next[sd] = level[ENTRY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_INTERP]) begin
            clip_reg <= clip_next;
            neg6_reg <= neg5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: restore the sign of the sum; output register
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] mix_reg  [SIDES];
    logic [SAMPLE_W-1:0] mix_next [SIDES];

    always_comb
    begin
        for (int sd = 0; sd < SIDES; sd++) begin
            mix_next[sd] = neg6_reg[sd] ? (~{1'b0, clip_reg[sd]} + 1'b1)
                                        : {1'b0, clip_reg[sd]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STG_OUT]) begin
            mix_reg <= mix_next;
        end
    end

    assign m_tdata = {mix_reg[RIGHT], mix_reg[LEFT]};

endmodule

FILE: rtl/smsc_checker.sv
// Port-level checker of the stereo mixer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smsc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [smsc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import smsc_pkg::*;

    // A waiting result stays offered
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // A waiting result keeps its value
    `ASSERT_NEXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // An empty output stage means room all the way back to the input
    `ASSERT_NOW(a_room_when_empty, clk, rst_n, !m_tvalid, s_tready, "input refused with empty output")

    // The soft clip is symmetric, so the most negative code never appears
    `ASSERT_NOW(a_no_neg_full, clk, rst_n, m_tvalid, (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000), "mix reached negative full scale")

endmodule

bind stereo_mixer_soft_clip_core smsc_checker u_smsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
